// File: rtl/fhft_pkg.sv
// shared constants and types for the frame history fuel tracker
package fhft_pkg;
    localparam int HISTORY_DEPTH   = 16;
    localparam int FRAME_PERIOD_MS = 64;
    localparam int RPM_SHIFT_BITS  = 6;
    localparam int SLOT_W          = $clog2(HISTORY_DEPTH);
    localparam int CNT_W           = $clog2(HISTORY_DEPTH + 1);
    localparam int DEN_W           = 8 + $clog2(FRAME_PERIOD_MS + 1);
    localparam int NUM_W           = 32 + 10 + 1;
    localparam int Q_BITS          = 9;

    localparam logic [2:0] KIND_RPM     = 3'd0;
    localparam logic [2:0] KIND_SPEED   = 3'd1;
    localparam logic [2:0] KIND_FUEL    = 3'd2;
    localparam logic [2:0] KIND_TICK    = 3'd3;
    localparam logic [2:0] KIND_RESTART = 3'd4;

    typedef struct packed {
        logic write_rpm;
        logic write_speed;
        logic fuel;
        logic restart;
        logic gate_check;
        logic scan_start;
        logic scan_step;
        logic div_start;
        logic div_step;
        logic advance;
    } fhft_cmd_t;

    typedef struct packed {
        logic gate_open;
        logic scan_done;
        logic div_done;
    } fhft_sts_t;
endpackage

// File: rtl/frame_history_fuel_tracker.sv
// top level of the frame history fuel tracker
// a sample or restart is applied as it is taken; a closed-gate tick gives its item the next cycle
// an open-gate tick gives its item after the ring scan (S_SCAN), the serial divider (S_DIV)
// and the output state (S_OUT), which presents it
// one item at a time; the next item is taken once the result has been collected
// rst_n clears rings, slot, sums, counter seed and frame time asynchronously
module frame_history_fuel_tracker
    import fhft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [15:0] rpm_raw,
    input  logic [7:0]  speed_kmh,
    input  logic [14:0] fuel_counter,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        frame_taken,
    output logic [7:0]  rpm_low,
    output logic [7:0]  rpm_high,
    output logic [7:0]  speed_low,
    output logic [7:0]  speed_high,
    output logic [7:0]  inst_consumption,
    output logic [31:0] trip_microlitres
);
    fhft_cmd_t  cmd;
    fhft_sts_t  sts;
    logic       hold_zero;
    logic [7:0] rl, rh, sl, sh, ic;

    fhft_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .out_valid(out_valid), .out_ready(out_ready),
        .frame_taken(frame_taken), .hold_zero(hold_zero), .cmd(cmd), .sts(sts)
    );

    fhft_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .rpm_raw(rpm_raw),
        .speed_kmh(speed_kmh), .fuel_counter(fuel_counter), .now_ms(now_ms),
        .rpm_low(rl), .rpm_high(rh), .speed_low(sl), .speed_high(sh),
        .inst_consumption(ic), .trip_microlitres(trip_microlitres)
    );

    assign rpm_low          = hold_zero ? 8'd0 : rl;
    assign rpm_high         = hold_zero ? 8'd0 : rh;
    assign speed_low        = hold_zero ? 8'd0 : sl;
    assign speed_high       = hold_zero ? 8'd0 : sh;
    assign inst_consumption = hold_zero ? 8'd0 : ic;
endmodule

// File: rtl/fhft_datapath.sv
// rings, sums, min/max scan and serial divider
module fhft_datapath
    import fhft_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  fhft_cmd_t        cmd,
    output fhft_sts_t        sts,
    input  logic [15:0]      rpm_raw,
    input  logic [7:0]       speed_kmh,
    input  logic [14:0]      fuel_counter,
    input  logic [31:0]      now_ms,
    output logic [7:0]       rpm_low,
    output logic [7:0]       rpm_high,
    output logic [7:0]       speed_low,
    output logic [7:0]       speed_high,
    output logic [7:0]       inst_consumption,
    output logic [31:0]      trip_microlitres
);
    logic [7:0]        rpm_ring_reg   [HISTORY_DEPTH];
    logic [7:0]        speed_ring_reg [HISTORY_DEPTH];
    logic [7:0]        cons_ring_reg  [HISTORY_DEPTH];
    logic [SLOT_W-1:0] slot_reg;
    logic [31:0]       next_time_reg;
    logic              primed_reg;
    logic [14:0]       last_cnt_reg;
    logic [31:0]       trip_reg, frame_reg;
    logic [CNT_W-1:0]  scan_reg;
    logic [7:0]        rl_reg, rh_reg, sl_reg, sh_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [Q_BITS-1:0] q_reg;
    logic [3:0]        bit_reg;
    logic              zero_reg;

    logic [15:0]       px;
    logic [7:0]        px8;
    logic [14:0]       delta;
    logic [31:0]       gap;
    logic [7:0]        r_at, s_at;
    logic [SLOT_W-1:0] nxt;
    logic [NUM_W-1:0]  num, dsh;
    logic [7:0]        cb;

    assign px    = rpm_raw >> RPM_SHIFT_BITS;
    assign px8   = (px > 16'd255) ? 8'hFF : px[7:0];
    assign delta = fuel_counter - last_cnt_reg;
    assign gap   = next_time_reg - now_ms;
    assign sts.gate_open = !(gap < 32'(FRAME_PERIOD_MS));
    assign sts.scan_done = (scan_reg == CNT_W'(HISTORY_DEPTH));
    assign sts.div_done  = (bit_reg == 4'd0);
    assign r_at = rpm_ring_reg[scan_reg[SLOT_W-1:0]];
    assign s_at = speed_ring_reg[scan_reg[SLOT_W-1:0]];
    assign nxt  = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
    assign num  = NUM_W'({frame_reg, 9'd0}) + NUM_W'({frame_reg, 7'd0}) +
                  NUM_W'({frame_reg, 6'd0}) + NUM_W'({frame_reg, 4'd0}) +
                  NUM_W'(DEN_W'(speed_ring_reg[slot_reg] * FRAME_PERIOD_MS) >> 1);
    assign dsh  = NUM_W'(den_reg) << (bit_reg - 4'd1);
    assign cb   = zero_reg ? 8'd0 : ((q_reg > 9'd255) ? 8'hFF : q_reg[7:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                rpm_ring_reg[i]   <= '0;
                speed_ring_reg[i] <= '0;
                cons_ring_reg[i]  <= '0;
            end
            slot_reg      <= '0;
            next_time_reg <= '0;
            primed_reg    <= 1'b0;
            last_cnt_reg  <= '0;
            trip_reg      <= '0;
            frame_reg     <= '0;
            scan_reg      <= '0;
            bit_reg       <= '0;
        end
        else if (cmd.restart)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                rpm_ring_reg[i]   <= '0;
                speed_ring_reg[i] <= '0;
                cons_ring_reg[i]  <= '0;
            end
            slot_reg      <= '0;
            next_time_reg <= '0;
            primed_reg    <= 1'b0;
            last_cnt_reg  <= '0;
            trip_reg      <= '0;
            frame_reg     <= '0;
        end
        else
        begin
            if (cmd.write_rpm)
                rpm_ring_reg[slot_reg] <= px8;
            if (cmd.write_speed)
                speed_ring_reg[slot_reg] <= speed_kmh;
            if (cmd.fuel)
            begin
                last_cnt_reg <= fuel_counter;
                primed_reg   <= 1'b1;
                if (primed_reg)
                begin
                    trip_reg  <= trip_reg + 32'(delta);
                    frame_reg <= frame_reg + 32'(delta);
                end
            end
            if (cmd.gate_check)
                next_time_reg <= now_ms + 32'(FRAME_PERIOD_MS);
            if (cmd.scan_start)
                scan_reg <= '0;
            if (cmd.scan_step)
                scan_reg <= scan_reg + 1'b1;
            if (cmd.div_start)
                bit_reg <= 4'(Q_BITS);
            if (cmd.div_step)
                bit_reg <= bit_reg - 4'd1;
            if (cmd.advance)
            begin
                frame_reg <= '0;
                rpm_ring_reg[nxt]   <= rpm_ring_reg[slot_reg];
                speed_ring_reg[nxt] <= speed_ring_reg[slot_reg];
                cons_ring_reg[nxt]  <= cb;
                slot_reg <= nxt;
            end
        end
    end

    // payload: scan extrema and divider
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            rl_reg <= 8'hFF;
            rh_reg <= 8'h00;
            sl_reg <= 8'hFF;
            sh_reg <= 8'h00;
        end
        else if (cmd.scan_step)
        begin
            if (r_at < rl_reg) rl_reg <= r_at;
            if (r_at > rh_reg) rh_reg <= r_at;
            if (s_at < sl_reg) sl_reg <= s_at;
            if (s_at > sh_reg) sh_reg <= s_at;
        end
        if (cmd.div_start)
        begin
            rem_reg  <= num;
            den_reg  <= DEN_W'(speed_ring_reg[slot_reg] * FRAME_PERIOD_MS);
            q_reg    <= '0;
            zero_reg <= (speed_ring_reg[slot_reg] == 8'd0) || (frame_reg == 32'd0);
        end
        else if (cmd.div_step)
        begin
            if (!zero_reg && (rem_reg >= dsh) && (den_reg != '0))
            begin
                rem_reg <= rem_reg - dsh;
                q_reg   <= q_reg | Q_BITS'(1 << (bit_reg - 4'd1));
            end
        end
    end

    // quotient of 9 bits saturates: if rem still holds >= 512*den, force 255
    logic big;
    assign big = !zero_reg && (rem_reg >= (NUM_W'(den_reg) << Q_BITS));

    assign rpm_low          = rl_reg;
    assign rpm_high         = rh_reg;
    assign speed_low        = sl_reg;
    assign speed_high       = sh_reg;
    assign inst_consumption = big ? 8'hFF : cb;
    assign trip_microlitres = trip_reg;
endmodule

// File: rtl/fhft_ctrl.sv
// controller state machine for the tracker
module fhft_ctrl
    import fhft_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [2:0] kind,
    output logic      out_valid,
    input  logic      out_ready,
    output logic      frame_taken,
    output logic      hold_zero,
    output fhft_cmd_t cmd,
    input  fhft_sts_t sts
);
    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DIV, S_OUT} state_t;
    state_t state_reg;
    logic   taken_reg, zero_reg, big_chk_reg;
    logic   acc;

    assign in_ready = (state_reg == S_IDLE) && !out_valid;
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        cmd = '0;
        cmd.write_rpm   = acc && (kind == KIND_RPM);
        cmd.write_speed = acc && (kind == KIND_SPEED);
        cmd.fuel        = acc && (kind == KIND_FUEL);
        cmd.restart     = acc && (kind == KIND_RESTART);
        cmd.gate_check  = acc && (kind == KIND_TICK) && sts.gate_open;
        cmd.scan_start  = cmd.gate_check;
        cmd.scan_step   = (state_reg == S_SCAN) && !sts.scan_done;
        cmd.div_start   = (state_reg == S_SCAN) && sts.scan_done;
        cmd.div_step    = (state_reg == S_DIV) && !sts.div_done;
        cmd.advance     = (state_reg == S_DIV) && sts.div_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            out_valid   <= 1'b0;
            taken_reg   <= 1'b0;
            zero_reg    <= 1'b0;
            big_chk_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (out_valid && out_ready)
                        out_valid <= 1'b0;
                    if (acc && kind == KIND_TICK)
                    begin
                        if (sts.gate_open)
                        begin
                            state_reg <= S_SCAN;
                            taken_reg <= 1'b1;
                            zero_reg  <= 1'b0;
                        end
                        else
                        begin
                            out_valid <= 1'b1;
                            taken_reg <= 1'b0;
                            zero_reg  <= 1'b1;
                        end
                    end
                end
                S_SCAN:
                    if (sts.scan_done)
                        state_reg <= S_DIV;
                S_DIV:
                    if (sts.div_done)
                        state_reg <= S_OUT;
                S_OUT:
                begin
                    big_chk_reg <= 1'b0;
                    out_valid   <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign frame_taken = taken_reg;
    assign hold_zero   = zero_reg | big_chk_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("ready while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |=> (state_reg == S_OUT)) else $error("advance without output");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule
